@@ sv/monotonic_cubic_interpolator_unit_macros.svh @@
// Assertion macros shared by the monotonic cubic interpolator RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef MONOTONIC_CUBIC_INTERPOLATOR_UNIT_MACROS_SVH
`define MONOTONIC_CUBIC_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCIP_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCIP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ sv/mcip_pkg.sv @@
// Package for the monotonic cubic interpolator: fixed constants.
// Used by the coefficient, Horner and top-level modules; depends on nothing.
`default_nettype none

package mcip_pkg;

   // Width of the threshold register and its reset value.
   localparam int THRESH_BITS = 16;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1;

   // Slice width of the wide operand in each partial-product multiplier.
   localparam int CHUNK_BITS = 32;

endpackage

`default_nettype wire

@@ sv/mcip_coef.sv @@
// Two-stage front end: differences, flatness and sign tests, cubic coefficients.
// Depends on mcip_pkg for the threshold width.
`default_nettype none

module mcip_coef #(
   parameter int SAMPLE_BITS   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [SAMPLE_BITS-1:0]       p0,
   input  logic signed [SAMPLE_BITS-1:0]       p1,
   input  logic signed [SAMPLE_BITS-1:0]       p2,
   input  logic signed [SAMPLE_BITS-1:0]       p3,
   input  logic        [FRACTION_BITS:0]       f,
   input  logic        [mcip_pkg::THRESH_BITS-1:0] threshold,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [SAMPLE_BITS+4:0]       a3,
   output logic signed [SAMPLE_BITS+4:0]       a2,
   output logic signed [SAMPLE_BITS:0]         d1,
   output logic signed [SAMPLE_BITS:0]         p1t,
   output logic        [FRACTION_BITS:0]       f_out
);
   localparam int DW = SAMPLE_BITS + 1;
   localparam int TW = SAMPLE_BITS + 5;
   localparam int FW = FRACTION_BITS + 1;

   logic              v1_ff, v2_ff;
   logic              en1, en2;

   logic signed [DW-1:0] d1_in, d2_in, ch_in, chn_in;
   logic        [DW-1:0] mag_in;
   logic signed [DW-1:0] d1_ff, d2_ff, ch_ff;
   logic        [DW-1:0] mag_ff;
   logic signed [SAMPLE_BITS-1:0] p1_ff;
   logic        [FW-1:0] f1_ff;

   logic                 keep;
   logic signed [DW-1:0] d1k, d2k;
   logic signed [TW-1:0] a3_in, a2_in;
   logic signed [TW-1:0] a3_ff, a2_ff;
   logic signed [DW-1:0] d1z_ff, p1t_ff;
   logic        [FW-1:0] f2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Stage 1: doubled tangents and the chord, with the chord magnitude
   // picked from two parallel subtractions.
   assign d1_in  = DW'(p2) - DW'(p0);
   assign d2_in  = DW'(p3) - DW'(p1);
   assign ch_in  = DW'(p2) - DW'(p1);
   assign chn_in = DW'(p1) - DW'(p2);
   assign mag_in = ch_in[DW-1] ? chn_in : ch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         ch_ff  <= ch_in;
         mag_ff <= mag_in;
         p1_ff  <= p1;
         f1_ff  <= f;
      end
   end

   // Stage 2: tangents survive only on a steep enough chord whose sign both
   // tangents share; a zero value counts as positive.
   assign keep = (mag_ff >= DW'(threshold)) &&
                 (ch_ff[DW-1] == d1_ff[DW-1]) && (ch_ff[DW-1] == d2_ff[DW-1]);
   assign d1k  = keep ? d1_ff : '0;
   assign d2k  = keep ? d2_ff : '0;

   assign a3_in = TW'(d1k) + TW'(d2k) - (TW'(ch_ff) <<< 2);
   assign a2_in = (TW'(ch_ff) <<< 2) + (TW'(ch_ff) <<< 1) - (TW'(d1k) <<< 1) - TW'(d2k);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         a3_ff  <= a3_in;
         a2_ff  <= a2_in;
         d1z_ff <= d1k;
         p1t_ff <= {p1_ff, 1'b1};
         f2_ff  <= f1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign a3        = a3_ff;
   assign a2        = a2_ff;
   assign d1        = d1z_ff;
   assign p1t       = p1t_ff;
   assign f_out     = f2_ff;

endmodule

`default_nettype wire

@@ sv/mcip_horner.sv @@
// Six-stage Horner evaluator: three multiply-add steps, each a stage of
// sliced partial products followed by a stage that sums them with the next term.
// Depends on mcip_pkg for the slice width.
`default_nettype none

module mcip_horner #(
   parameter int SAMPLE_BITS   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic signed [SAMPLE_BITS+4:0]                  a3,
   input  logic signed [SAMPLE_BITS+4:0]                  a2,
   input  logic signed [SAMPLE_BITS:0]                    d1,
   input  logic signed [SAMPLE_BITS:0]                    p1t,
   input  logic        [FRACTION_BITS:0]                  f,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic signed [SAMPLE_BITS+3*FRACTION_BITS+5:0]  acc
);
   import mcip_pkg::*;

   localparam int FW  = FRACTION_BITS + 1;
   localparam int TW  = SAMPLE_BITS + 5;
   localparam int AW  = SAMPLE_BITS + 3 * FRACTION_BITS + 6;
   localparam int CW  = CHUNK_BITS;
   localparam int NC  = (AW + CW - 1) / CW;
   localparam int XEW = NC * CW;
   localparam int PW  = CW + FW + 1;
   localparam int NS  = 6;
   localparam int NT  = 3;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS:0]   stage_en;

   logic        [FW-1:0] f_ff   [NS-1];
   logic        [FW-1:0] f_src  [NS-1];
   logic signed [TW-1:0] tm_ff  [NS-1][NT];
   logic signed [TW-1:0] tm_src [NS-1][NT];

   logic signed [AW-1:0] acc_q [NT];

   // A stage takes a new word when it is empty or its own word moves on.
   always_comb begin
      stage_en[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   assign in_ready = stage_en[0];
   assign v_src    = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_en[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   // Fraction and the later terms ride along with each word.
   always_comb begin
      f_src[0]     = f;
      tm_src[0][0] = TW'(a2);
      tm_src[0][1] = TW'(d1);
      tm_src[0][2] = TW'(p1t);
      for (int i = 1; i < NS - 1; i++) begin
         f_src[i] = f_ff[i-1];
         for (int j = 0; j < NT; j++) begin
            tm_src[i][j] = tm_ff[i-1][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS - 1; i++) begin
         if (stage_en[i]) begin
            f_ff[i] <= f_src[i];
            for (int j = 0; j < NT; j++) begin
               tm_ff[i][j] <= tm_src[i][j];
            end
         end
      end
   end

   for (genvar k = 0; k < NT; k++) begin : g_step
      logic signed [XEW-1:0] xe;
      logic signed [PW-1:0]  pp_in [NC];
      logic signed [PW-1:0]  pp_ff [NC];
      logic signed [AW-1:0]  acc_in;
      logic signed [AW-1:0]  acc_ff;

      if (k == 0) begin : g_first
         assign xe = XEW'(a3);
      end else begin : g_next
         assign xe = XEW'(acc_q[k-1]);
      end

      // Low slices are unsigned; only the top slice carries the sign.
      for (genvar c = 0; c < NC; c++) begin : g_slice
         if (c == NC - 1) begin : g_top
            assign pp_in[c] = $signed(xe[c*CW +: CW]) * $signed({1'b0, f_src[2*k]});
         end else begin : g_low
            assign pp_in[c] = $signed({1'b0, xe[c*CW +: CW]}) *
                              $signed({1'b0, f_src[2*k]});
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[2*k]) begin
            pp_ff <= pp_in;
         end
      end

      always_comb begin
         acc_in = AW'(tm_ff[2*k][k]) <<< ((k + 1) * FRACTION_BITS);
         for (int c = 0; c < NC; c++) begin
            acc_in = acc_in + (AW'(pp_ff[c]) << (c * CW));
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[2*k+1]) begin
            acc_ff <= acc_in;
         end
      end

      assign acc_q[k] = acc_ff;
   end

   assign out_valid = v_ff[NS-1];
   assign acc       = acc_q[NT-1];

endmodule

`default_nettype wire

@@ sv/mcip_round.sv @@
// Output stage: drops the fraction bits (the half-unit bias is already in),
// clamps to the sample range and holds the result word for the receiver.
// Depends on nothing besides its parameters.
`default_nettype none

module mcip_round #(
   parameter int SAMPLE_BITS   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic signed [SAMPLE_BITS+3*FRACTION_BITS+5:0]  acc,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic signed [SAMPLE_BITS-1:0]                  out_value,
   output logic                                           out_sat
);
   localparam int AW = SAMPLE_BITS + 3 * FRACTION_BITS + 6;
   localparam int VW = SAMPLE_BITS + 5;

   logic                         en;
   logic                         v_ff;
   logic signed [VW-1:0]         val;
   logic        [VW-SAMPLE_BITS:0] top;
   logic                         fits;
   logic signed [SAMPLE_BITS-1:0] value_in, value_ff;
   logic                         sat_in, sat_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   assign val  = acc[AW-1:AW-VW];
   assign top  = val[VW-1:SAMPLE_BITS-1];
   assign fits = (&top) || !(|top);

   always_comb begin
      sat_in = !fits;
      if (fits) begin
         value_in = val[SAMPLE_BITS-1:0];
      end else if (val[VW-1]) begin
         value_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         value_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = v_ff;
   assign out_value = value_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

@@ sv/monotonic_cubic_interpolator_unit.sv @@
// Top level of the monotonic cubic interpolator and its threshold register.
// Depends on mcip_pkg, mcip_coef, mcip_horner, mcip_round and the macro header.
//
// Usage:
//   Request channel (req_valid/req_ready) carries four consecutive samples
//   p0..p3 and a fraction t; each request word yields exactly one response
//   word (rsp_valid/rsp_ready) with the interpolated sample and a flag that
//   is set when the value was clamped to the sample range.
//   The threshold register is written through csr_write_enable and
//   csr_write_data and takes effect on the next word; write it only while
//   the pipeline is empty.
//   Path from request to response: two coefficient stages,
//   six Horner stages (three multiply-add steps of two stages each) and one
//   output register. One word is accepted per cycle: every stage hands its
//   word on whenever the stage after it is empty or moving its own word on.
//   When the receiver stalls, words keep entering until the empty stages
//   ahead of the output register are filled; then req_ready goes low.
//   Synchronous reset empties every stage and sets the threshold to one.
`default_nettype none

`include "monotonic_cubic_interpolator_unit_macros.svh"

module monotonic_cubic_interpolator_unit #(
   parameter int SAMPLE_BITS   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mcip_pkg::THRESH_BITS-1:0]    csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_before,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_start,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_end,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_after,
   input  logic        [FRACTION_BITS:0]       req_fraction,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_interpolated,
   output logic                                rsp_saturated
);
   import mcip_pkg::*;

   localparam int TW = SAMPLE_BITS + 5;
   localparam int AW = SAMPLE_BITS + 3 * FRACTION_BITS + 6;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [THRESH_BITS-1:0] threshold_ff, threshold_in;

   logic                          coef_valid, coef_ready;
   logic signed [TW-1:0]          coef_a3, coef_a2;
   logic signed [SAMPLE_BITS:0]   coef_d1, coef_p1t;
   logic        [FRACTION_BITS:0] coef_f;

   logic                          poly_valid, poly_ready;
   logic signed [AW-1:0]          poly_acc;

   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   mcip_coef #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .p0        (req_sample_before),
      .p1        (req_sample_start),
      .p2        (req_sample_end),
      .p3        (req_sample_after),
      .f         (req_fraction),
      .threshold (threshold_ff),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .a3        (coef_a3),
      .a2        (coef_a2),
      .d1        (coef_d1),
      .p1t       (coef_p1t),
      .f_out     (coef_f)
   );

   mcip_horner #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_horner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (coef_valid),
      .in_ready  (coef_ready),
      .a3        (coef_a3),
      .a2        (coef_a2),
      .d1        (coef_d1),
      .p1t       (coef_p1t),
      .f         (coef_f),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .acc       (poly_acc)
   );

   mcip_round #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .acc       (poly_acc),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (rsp_interpolated),
      .out_sat   (rsp_saturated)
   );

   // A clamped result must sit exactly on one end of the sample range.
   `MCIP_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated,
      (rsp_interpolated == SAMPLE_MAX) || (rsp_interpolated == SAMPLE_MIN),
      "saturated result is not at a range limit")

   // The request side can only be held off by a full output register.
   `MCIP_ASSERT_NOW(a_stall_needs_full_output, clock, reset, !req_ready,
      rsp_valid && !rsp_ready, "request stalled while output can drain")

   // A register write lands on the next edge.
   `MCIP_ASSERT_NEXT(a_csr_write_lands, clock, reset, csr_write_enable,
      threshold_ff == $past(csr_write_data), "threshold write was lost")

endmodule

`default_nettype wire

@@ test/monotonic_cubic_interpolator_unit_tb.sv @@
// Self-checking testbench for monotonic_cubic_interpolator_unit.
// Depends on mcip_pkg and the unit RTL; predicts each response word exactly
// and compares it with the word the unit returns.
`default_nettype none

module monotonic_cubic_interpolator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_WIDTH    = FRACTION_BITS + 1;
   localparam int THRESH_WIDTH  = mcip_pkg::THRESH_BITS;
   localparam int UNIT          = 1 << FRACTION_BITS;
   localparam int LATENCY       = 9;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int RANDOM_WORDS  = 100;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] p0;
      logic signed [SAMPLE_BITS-1:0] p1;
      logic signed [SAMPLE_BITS-1:0] p2;
      logic signed [SAMPLE_BITS-1:0] p3;
      logic [FRACTION_BITS:0]        frac;
   } control_word_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          clipped;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [mcip_pkg::THRESH_BITS-1:0] csr_write_data;
   logic req_valid;
   logic req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_before;
   logic signed [SAMPLE_BITS-1:0] req_sample_start;
   logic signed [SAMPLE_BITS-1:0] req_sample_end;
   logic signed [SAMPLE_BITS-1:0] req_sample_after;
   logic [FRACTION_BITS:0] req_fraction;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_interpolated;
   logic rsp_saturated;

   logic [mcip_pkg::THRESH_BITS-1:0] flat_threshold = mcip_pkg::THRESH_RESET;
   sample_word_type pending_values[$];
   sample_word_type head_value;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   monotonic_cubic_interpolator_unit #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_before(req_sample_before),
      .req_sample_start(req_sample_start),
      .req_sample_end(req_sample_end),
      .req_sample_after(req_sample_after),
      .req_fraction(req_fraction),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_interpolated(rsp_interpolated),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_values.size());
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return SAMPLE_BITS'(SAMPLE_MIN);
      return SAMPLE_BITS'(v);
   endfunction

   // Tangents are kept doubled so they stay exact; the cubic is evaluated in
   // Horner form at scale 2^(3*FRACTION_BITS+1) and shifted back at the end.
   function automatic sample_word_type cubic_value(logic signed [SAMPLE_BITS-1:0] s0,
                                                   logic signed [SAMPLE_BITS-1:0] s1,
                                                   logic signed [SAMPLE_BITS-1:0] s2,
                                                   logic signed [SAMPLE_BITS-1:0] s3,
                                                   logic [FRACTION_BITS:0] frac,
                                                   logic [mcip_pkg::THRESH_BITS-1:0] thr);
      longint p0, p1, p2, p3, d1, d2, chord, dd, mag, a3, a2;
      logic signed [159:0] acc, term, ft, top, bottom;
      sample_word_type r;
      p0 = s0;
      p1 = s1;
      p2 = s2;
      p3 = s3;
      d1 = p2 - p0;
      d2 = p3 - p1;
      chord = p2 - p1;
      dd = 2 * chord;
      mag = (chord < 0) ? -chord : chord;
      if (mag < longint'(thr) || (chord < 0) != (d1 < 0) || (chord < 0) != (d2 < 0)) begin
         d1 = 0;
         d2 = 0;
      end
      a3 = d1 + d2 - 2 * dd;
      a2 = 3 * dd - 2 * d1 - d2;
      ft = frac;
      acc = a3;
      acc = acc * ft;
      term = a2;
      acc = acc + (term <<< FRACTION_BITS);
      acc = acc * ft;
      term = d1;
      acc = acc + (term <<< (2 * FRACTION_BITS));
      acc = acc * ft;
      // The extra one is half an output unit at this scale, for rounding half up.
      term = 2 * p1 + 1;
      acc = acc + (term <<< (3 * FRACTION_BITS));
      acc = acc >>> (3 * FRACTION_BITS + 1);
      top = SAMPLE_MAX;
      bottom = SAMPLE_MIN;
      r.clipped = 1'b1;
      if (acc > top) begin
         r.value = SAMPLE_BITS'(SAMPLE_MAX);
      end else if (acc < bottom) begin
         r.value = SAMPLE_BITS'(SAMPLE_MIN);
      end else begin
         r.value = acc[SAMPLE_BITS-1:0];
         r.clipped = 1'b0;
      end
      return r;
   endfunction

   task automatic note_mismatch(string what, sample_word_type want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0d: %s: expected %0d sat %0b, got %0d sat %0b", cycle_count, what,
                  want.value, want.clipped, rsp_interpolated, rsp_saturated);
      end
   endtask

   // Responses are checked before requests are recorded, all on pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_values.size() == 0) begin
               head_value.value = 'x;
               head_value.clipped = 1'bx;
               note_mismatch("response word with none expected", head_value);
            end else begin
               head_value = pending_values.pop_front();
               if (rsp_interpolated !== head_value.value ||
                   rsp_saturated !== head_value.clipped) begin
                  note_mismatch("response word mismatch", head_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_values.push_back(cubic_value(req_sample_before, req_sample_start,
                                                 req_sample_end, req_sample_after,
                                                 req_fraction, flat_threshold));
         end
      end
   end

   task automatic send_word(longint s0, longint s1, longint s2, longint s3, int frac);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_before <= SAMPLE_BITS'(s0);
      req_sample_start <= SAMPLE_BITS'(s1);
      req_sample_end <= SAMPLE_BITS'(s2);
      req_sample_after <= SAMPLE_BITS'(s3);
      req_fraction <= FRAC_WIDTH'(frac);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_threshold(logic [mcip_pkg::THRESH_BITS-1:0] thr);
      drain_pipeline();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= thr;
      @(posedge clock);
      flat_threshold = thr;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic control_word_type random_word();
      control_word_type w;
      longint pt[4];
      longint corner[5];
      longint step_mask, k;
      int mode;
      bit falling;
      corner[0] = SAMPLE_MIN;
      corner[1] = SAMPLE_MIN + 1;
      corner[2] = 0;
      corner[3] = SAMPLE_MAX - 1;
      corner[4] = SAMPLE_MAX;
      mode = $urandom_range(0, 9);
      falling = 1'($urandom_range(0, 1));
      step_mask = (longint'(1) << (2 + 7 * $urandom_range(0, 4))) - 1;
      pt[0] = longint'(int'($urandom));
      for (int i = 1; i < 4; i++) begin
         k = longint'($urandom) & step_mask;
         pt[i] = falling ? pt[i-1] - k : pt[i-1] + k;
      end
      case (mode)
         6: begin
            // Chord right around the flatness threshold.
            k = longint'(flat_threshold) + $urandom_range(0, 4) - 2;
            pt[2] = falling ? pt[1] - k : pt[1] + k;
         end
         7: begin
            for (int i = 0; i < 4; i++) pt[i] = longint'(int'($urandom));
         end
         8: begin
            for (int i = 0; i < 4; i++) pt[i] = corner[$urandom_range(0, 4)];
         end
         9: begin
            pt[$urandom_range(0, 3)] = longint'(int'($urandom));
         end
         default: ;
      endcase
      w.p0 = clamp_sample(pt[0]);
      w.p1 = clamp_sample(pt[1]);
      w.p2 = clamp_sample(pt[2]);
      w.p3 = clamp_sample(pt[3]);
      if ($urandom_range(99) < 85) w.frac = FRAC_WIDTH'($urandom_range(0, UNIT));
      else w.frac = FRAC_WIDTH'($urandom_range(0, 2 * UNIT - 1));
      return w;
   endfunction

   // Threshold of one after reset: only a zero chord is flat.
   task automatic test_reset_threshold();
      send_word(0, 0, 0, 0, 0);
      send_word(-100, 5, 5, 200, UNIT / 2);
      send_word(0, 0, 1, 1, UNIT / 2);
      send_word(0, UNIT, 2 * UNIT, 3 * UNIT, UNIT / 2);
      send_word(3 * UNIT, 2 * UNIT, UNIT, 0, UNIT / 4);
   endtask

   task automatic test_field_extremes();
      send_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, UNIT);
      send_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 0);
      send_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, UNIT / 2);
      send_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, UNIT - 1);
      send_word(SAMPLE_MIN, SAMPLE_MAX - UNIT, SAMPLE_MAX, SAMPLE_MAX, UNIT / 2);
      send_word(SAMPLE_MAX, SAMPLE_MIN + UNIT, SAMPLE_MIN, SAMPLE_MIN, UNIT / 2);
   endtask

   // A tangent whose sign disagrees with the chord flattens the segment.
   task automatic test_tangent_limits();
      send_word(1000, 0, 10, 20, UNIT / 3);
      send_word(0, 5, 10, -1000, UNIT / 3);
      send_word(-1000, 0, -10, 20, UNIT / 3);
   endtask

   // Fractions above one extrapolate beyond the segment and can clip.
   task automatic test_extrapolation();
      send_word(0, UNIT, 2 * UNIT, 3 * UNIT, UNIT + 1);
      send_word(SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MAX, 2 * UNIT - 1);
      send_word(SAMPLE_MAX, 0, SAMPLE_MIN, SAMPLE_MIN, 2 * UNIT - 1);
   endtask

   task automatic test_threshold_edges();
      write_threshold(16'hFFFF);
      send_word(-70000, 0, 65534, 140000, UNIT / 2);
      send_word(-70000, 0, 65535, 140000, UNIT / 2);
      write_threshold(16'h0000);
      // A zero chord counts as rising, so only rising tangents survive.
      send_word(0, 50, 50, 100, UNIT / 3);
      send_word(100, 50, 50, 0, UNIT / 3);
   endtask

   task automatic run_random_phase(int idle, int stall, int thr);
      control_word_type w;
      write_threshold(THRESH_WIDTH'(thr));
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (RANDOM_WORDS) begin
         w = random_word();
         send_word(w.p0, w.p1, w.p2, w.p3, w.frac);
      end
   endtask

   task automatic test_random_stream();
      run_random_phase(0, 0, $urandom_range(2, 4000));
      run_random_phase(51, 0, 16'h0000);
      run_random_phase(0, 51, 16'hFFFF);
      run_random_phase(7, 7, $urandom_range(1, 65534));
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_sample_before = '0;
      req_sample_start = '0;
      req_sample_end = '0;
      req_sample_after = '0;
      req_fraction = '0;
      rsp_ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_threshold();
      test_field_extremes();
      test_tangent_limits();
      test_extrapolation();
      test_threshold_edges();
      test_random_stream();
      drain_pipeline();
      if (mismatch_count == 0 && pending_values.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
